// File: src/dfrp_pkg.sv
package dfrp_pkg;

    // FIFO geometry and fixed-point format
    localparam int FIFO_DEPTH    = 2048;
    localparam int FRACTION_BITS = 12;
    localparam int ADDR_W        = $clog2(FIFO_DEPTH);
    localparam int POS_W         = ADDR_W + FRACTION_BITS;
    localparam int PEND_W        = POS_W + 1;

    // Step and rate arithmetic
    localparam int STEP_W        = 20;
    localparam int DAC_CLOCK_HZ  = 1000000;
    localparam int RATE_W        = $clog2(DAC_CLOCK_HZ + 1);
    localparam int DIV_W         = RATE_W + FRACTION_BITS;
    localparam int DIVR_W        = 17;

    localparam logic [STEP_W-1:0] STEP_MAX          = {STEP_W{1'b1}};
    localparam logic [DIVR_W-1:0] OUTPUT_RATE_RESET = 17'd22050;

    // Byte codes
    localparam logic [7:0] SILENCE     = 8'h80;
    localparam logic [7:0] READ_ONES   = 8'hFF;
    localparam logic [7:0] READ_ZERO   = 8'h00;
    localparam logic [7:0] ST_FULL     = 8'h08;
    localparam logic [7:0] ST_EMPTY    = 8'h04;
    localparam logic [7:0] ST_NEAR     = 8'h02;
    localparam logic [7:0] ST_IRQ      = 8'h01;
    localparam int         NEARLY_EMPTY_BYTES = 128;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request kinds on the input channel
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Register offsets
    localparam logic [2:0] OFF_DATA    = 3'd0;
    localparam logic [2:0] OFF_CMD     = 3'd2;
    localparam logic [2:0] OFF_DIVISOR = 3'd3;
    localparam logic [2:0] OFF_RESET   = 3'd4;
    localparam logic [2:0] OFF_SPARE_A = 3'd5;
    localparam logic [2:0] OFF_SPARE_B = 3'd6;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] port_offset;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] sample;
        logic       irq_level;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DATA,
        OP_CMD,
        OP_DIV,
        OP_CLEAR,
        OP_READ,
        OP_TICK
    } op_kind_t;

    typedef enum logic [2:0] {
        RD_CMD,
        RD_STATUS,
        RD_DIVISOR,
        RD_ZERO,
        RD_ONES
    } rd_sel_t;

    typedef struct packed {
        op_kind_t   kind;
        rd_sel_t    rd_sel;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC,
        BK_DIV1,
        BK_DIV2,
        BK_DIVFIN
    } back_state_t;

endpackage

// File: src/dfrp_front.sv
module dfrp_front
    import dfrp_pkg::*;
(
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     q_full,
    output logic     push,
    output op_t      push_op
);

    // Accept whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Classify the item into one back-end operation
    always_comb
    begin
        push_op.kind   = OP_NOP;
        push_op.rd_sel = RD_ONES;
        push_op.data   = in_item.write_data;
        case (in_item.req_type)
            REQ_WRITE:
            begin
                case (in_item.port_offset)
                    OFF_DATA:    push_op.kind = OP_DATA;
                    OFF_CMD:     push_op.kind = OP_CMD;
                    OFF_DIVISOR: push_op.kind = OP_DIV;
                    OFF_RESET:
                    begin
                        if (in_item.write_data == 8'd0)
                        begin
                            push_op.kind = OP_CLEAR;
                        end
                    end
                    default:     push_op.kind = OP_NOP;
                endcase
            end
            REQ_READ:
            begin
                push_op.kind = OP_READ;
                if (in_item.port_offset == OFF_DATA)
                begin
                    push_op.rd_sel = RD_CMD;
                end
                else if (in_item.port_offset == OFF_CMD)
                begin
                    push_op.rd_sel = RD_STATUS;
                end
                else if (in_item.port_offset == OFF_DIVISOR)
                begin
                    push_op.rd_sel = RD_DIVISOR;
                end
                else if (in_item.port_offset inside {OFF_SPARE_A, OFF_SPARE_B})
                begin
                    push_op.rd_sel = RD_ZERO;
                end
            end
            REQ_TICK: push_op.kind = OP_TICK;
            default:  push_op.kind = OP_NOP;
        endcase
    end

endmodule

// File: src/dfrp_queue.sv
module dfrp_queue
    import dfrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output op_t  head_op
);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: src/dfrp_div.sv
module dfrp_div
    import dfrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              busy,
    output logic [DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] rem_next;
    logic [DIV_W-1:0]  quot_reg;
    logic [DIV_W-1:0]  quot_next;
    logic [DIVR_W-1:0] dvsr_reg;
    logic [DIVR_W-1:0] dvsr_next;
    logic [DIVR_W:0]   shifted;
    logic [DIVR_W:0]   trial;

    assign busy     = busy_reg;
    assign quotient = quot_reg;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quot_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            rem_next  = '0;
            quot_next = req.dividend;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvsr_reg})
            begin
                rem_next  = trial[DIVR_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DIVR_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvsr_reg <= dvsr_next;
    end

endmodule

// File: src/dfrp_back.sv
module dfrp_back
    import dfrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  op_t               head_op,
    output logic              pop,
    input  logic              cfg_valid,
    input  logic [DIVR_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item
);

    localparam int CMP_W = (PEND_W > STEP_W) ? PEND_W : STEP_W;
    localparam int SUM_W = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;

    localparam logic [PEND_W-1:0] PEND_ONE   = PEND_W'(1 << FRACTION_BITS);
    localparam logic [PEND_W-1:0] PEND_MAX   = PEND_W'(FIFO_DEPTH << FRACTION_BITS);
    localparam logic [PEND_W-1:0] FULL_LIMIT =
        PEND_W'((FIFO_DEPTH - 1) << FRACTION_BITS);
    localparam logic [PEND_W-1:0] NEAR_LIMIT =
        PEND_W'(NEARLY_EMPTY_BYTES << FRACTION_BITS);
    localparam logic [ADDR_W-1:0] CLR_LAST   = {ADDR_W{1'b1}};

    back_state_t       state_reg;
    back_state_t       state_next;
    op_t               op_reg;
    op_t               op_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic [ADDR_W-1:0] wr_idx_reg;
    logic [ADDR_W-1:0] wr_idx_next;
    logic [POS_W-1:0]  rpos_reg;
    logic [POS_W-1:0]  rpos_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic              irq_status_reg;
    logic              irq_status_next;
    logic              irq_armed_reg;
    logic              irq_armed_next;
    logic              irq_line_reg;
    logic              irq_line_next;
    logic [7:0]        cmd_reg;
    logic [7:0]        cmd_next;
    logic [7:0]        divisor_reg;
    logic [7:0]        divisor_next;
    logic [DIVR_W-1:0] rate_reg;
    logic [DIVR_W-1:0] rate_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_item_reg;
    out_item_t         out_item_next;

    logic [7:0]        store_mem [FIFO_DEPTH];
    logic [7:0]        mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    div_req_t          div_req;
    logic              div_busy;
    logic [DIV_W-1:0]  div_quot;

    logic              out_free;
    logic              emit;
    out_item_t         result;
    logic              pend_zero;
    logic              near_empty;
    logic              store_full;
    logic              irq_fire;
    logic [7:0]        status_byte;
    logic [PEND_W:0]   pend_sum;
    logic [SUM_W-1:0]  rpos_sum;
    logic [CMP_W-1:0]  pend_ext;
    logic [CMP_W-1:0]  step_ext;
    logic [CMP_W-1:0]  pend_diff;
    logic [8:0]        div_plus1;

    dfrp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Status flags from the current pending amount
    assign pend_zero  = (pend_reg == '0);
    assign near_empty = (pend_reg < NEAR_LIMIT) && (cmd_reg[1:0] == 2'b11);
    assign store_full = (pend_reg > FULL_LIMIT);
    assign irq_fire   = near_empty && irq_armed_reg;
    assign status_byte = (irq_status_reg ? ST_IRQ : 8'h00) |
                         (pend_zero ? ST_EMPTY : 8'h00) |
                         (near_empty ? ST_NEAR : 8'h00) |
                         (store_full ? ST_FULL : 8'h00);

    // Fixed-point arithmetic for writes and ticks
    assign pend_sum  = {1'b0, pend_reg} + {1'b0, PEND_ONE};
    assign rpos_sum  = SUM_W'(rpos_reg) + SUM_W'(step_reg);
    assign pend_ext  = CMP_W'(pend_reg);
    assign step_ext  = CMP_W'(step_reg);
    assign pend_diff = pend_ext - step_ext;
    assign div_plus1 = {1'b0, op_reg.data} + 9'd1;
    assign mem_raddr = rpos_reg[POS_W-1:FRACTION_BITS];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (op_reg.kind == OP_DIV)
                begin
                    state_next = BK_DIV1;
                end
                else if (out_free)
                begin
                    state_next = (op_reg.kind == OP_CLEAR) ? BK_CLEAR : BK_IDLE;
                end
            end
            BK_DIV1:
            begin
                if (!div_busy)
                begin
                    state_next = BK_DIV2;
                end
            end
            BK_DIV2:
            begin
                if (!div_busy)
                begin
                    state_next = BK_DIVFIN;
                end
            end
            BK_DIVFIN:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath, memory and divider control
    always_comb
    begin
        op_next          = op_reg;
        clr_cnt_next     = clr_cnt_reg;
        wr_idx_next      = wr_idx_reg;
        rpos_next        = rpos_reg;
        step_next        = step_reg;
        pend_next        = pend_reg;
        irq_status_next  = irq_status_reg;
        irq_armed_next   = irq_armed_reg;
        irq_line_next    = irq_line_reg;
        cmd_next         = cmd_reg;
        divisor_next     = divisor_reg;
        rate_next        = cfg_valid ? cfg_data : rate_reg;
        pop              = 1'b0;
        emit             = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = wr_idx_reg;
        mem_wdata        = op_reg.data;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(DAC_CLOCK_HZ);
        div_req.divisor  = DIVR_W'(div_plus1);
        result.read_data = READ_ZERO;
        result.sample    = SILENCE;
        result.irq_level = 1'b0;

        case (state_reg)
            BK_CLEAR:
            begin
                // Sweep silence through the store
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = SILENCE;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            BK_IDLE:
            begin
                pop = head_valid;
                if (head_valid)
                begin
                    op_next = head_op;
                end
            end
            BK_EXEC:
            begin
                if (op_reg.kind == OP_DIV)
                begin
                    // First division: DAC clock over divisor plus one
                    div_req.start = 1'b1;
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                    case (op_reg.kind)
                        OP_DATA:
                        begin
                            if (!store_full)
                            begin
                                mem_we      = 1'b1;
                                wr_idx_next = wr_idx_reg + 1'b1;
                                pend_next   = (pend_sum > {1'b0, PEND_MAX}) ?
                                              PEND_MAX : pend_sum[PEND_W-1:0];
                            end
                        end
                        OP_CMD:
                        begin
                            cmd_next = op_reg.data;
                            if (op_reg.data[1:0] != 2'b00)
                            begin
                                irq_armed_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            wr_idx_next    = '0;
                            rpos_next      = '0;
                            step_next      = '0;
                            pend_next      = '0;
                            irq_line_next  = 1'b0;
                            irq_armed_next = 1'b0;
                            clr_cnt_next   = '0;
                        end
                        OP_READ:
                        begin
                            case (op_reg.rd_sel)
                                RD_CMD:     result.read_data = cmd_reg;
                                RD_STATUS:  result.read_data = status_byte;
                                RD_DIVISOR: result.read_data = divisor_reg;
                                RD_ZERO:    result.read_data = READ_ZERO;
                                default:    result.read_data = READ_ONES;
                            endcase
                        end
                        OP_TICK:
                        begin
                            if (irq_fire)
                            begin
                                irq_status_next = 1'b1;
                                irq_armed_next  = 1'b0;
                                irq_line_next   = 1'b1;
                            end
                            if (!pend_zero)
                            begin
                                result.sample = mem_rdata_reg;
                                rpos_next     = rpos_sum[POS_W-1:0];
                                pend_next     = (step_ext >= pend_ext) ?
                                                '0 : pend_diff[PEND_W-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_DIV1:
            begin
                if (!div_busy)
                begin
                    // Second division: scaled DAC rate over output rate
                    div_req.start    = 1'b1;
                    div_req.dividend = {div_quot[RATE_W-1:0], {FRACTION_BITS{1'b0}}};
                    div_req.divisor  = rate_reg;
                end
            end
            BK_DIVFIN:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    divisor_next = op_reg.data;
                    if (rate_reg == '0 || div_quot[DIV_W-1:STEP_W] != '0)
                    begin
                        step_next = STEP_MAX;
                    end
                    else
                    begin
                        step_next = div_quot[STEP_W-1:0];
                    end
                    if (irq_fire)
                    begin
                        irq_status_next = 1'b1;
                        irq_armed_next  = 1'b0;
                        irq_line_next   = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.irq_level = irq_line_next;

        // Hold the result until the consumer takes it
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_item_next  = emit ? result : out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            clr_cnt_reg    <= '0;
            wr_idx_reg     <= '0;
            rpos_reg       <= '0;
            step_reg       <= '0;
            pend_reg       <= '0;
            irq_status_reg <= 1'b0;
            irq_armed_reg  <= 1'b0;
            irq_line_reg   <= 1'b0;
            cmd_reg        <= '0;
            divisor_reg    <= '0;
            rate_reg       <= OUTPUT_RATE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            wr_idx_reg     <= wr_idx_next;
            rpos_reg       <= rpos_next;
            step_reg       <= step_next;
            pend_reg       <= pend_next;
            irq_status_reg <= irq_status_next;
            irq_armed_reg  <= irq_armed_next;
            irq_line_reg   <= irq_line_next;
            cmd_reg        <= cmd_next;
            divisor_reg    <= divisor_next;
            rate_reg       <= rate_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        out_item_reg <= out_item_next;
    end

    // Sample store: one write port, registered read at the play position
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= store_mem[mem_raddr];
    end

    // Pending amount never passes one full FIFO
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_MAX)
        else $error("pending amount above FIFO capacity");

    // No item leaves the queue while the store is being cleared
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_CLEAR |-> !pop)
        else $error("queue popped during clearing pass");

    // The IRQ line is only ever raised together with the sticky status bit
    a_irq_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        irq_line_reg |-> irq_status_reg)
        else $error("IRQ line high without status bit");

    // The divider runs only while the sequencer waits on it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == BK_DIV1 || state_reg == BK_DIV2))
        else $error("divider busy outside divisor sequence");

endmodule

// File: src/dac_fifo_rate_playback.sv
// 8-bit DAC playback with a 2048-byte FIFO behind a small bus register set. Each
// input item is a bus write, a bus read or one output sample tick, and gives
// exactly one result item. Items are decoded in front and held in a two-entry
// queue, so up to two items are taken while the back end is busy or a result
// waits. Bus reads and writes and sample ticks pass the idle and execute
// states of the back end, which stays in execute until the output register is
// free. For a divisor write the step is worked out by two back-to-back 32-step
// divisions in one shared bit-serial divider, awaited in the DIV1 and DIV2
// states. After reset, and after a zero is written to the reset register, a
// clearing pass writes silence to all 2048 FIFO bytes, one per cycle; no item
// is carried out during the pass (items still queue, and the output-rate
// register can be written at any time, cfg_ready being always high).
module dac_fifo_rate_playback
    import dfrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DIVR_W-1:0] cfg_data
);

    logic q_full;
    logic push;
    op_t  push_op;
    logic pop;
    logic head_valid;
    op_t  head_op;

    assign cfg_ready = 1'b1;

    dfrp_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op)
    );

    dfrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    dfrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
